// ----- design/tpvp_pkg.sv -----
// Shared types and constants of the timed pump, vent and purge sequencer.
package tpvp_pkg;

  localparam int unsigned DUR_BITS = 24;
  localparam int unsigned CNT_BITS = 8;
  localparam int unsigned PHASE_BITS = 4;
  localparam int unsigned REG_IDX_BITS = 3;

  // Phase codes.
  localparam logic [PHASE_BITS-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_PUMP       = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_PUMP_IDLE  = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_VENT       = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_VENT_IDLE  = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_FINAL_VENT = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_FINAL_IDLE = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_MAN_ON     = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_MAN_IDLE   = 4'd8;

  // Configuration register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_PUMP_TIME       = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_VENT_TIME       = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_IDLE_TIME       = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MANUAL_TIME     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CYCLE_TOTAL     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_FINAL_VENT_TIME = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_DEBOUNCE_TIME   = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [DUR_BITS-1:0] RST_PUMP_TIME       = 24'd75000;
  localparam logic [DUR_BITS-1:0] RST_VENT_TIME       = 24'd13500;
  localparam logic [DUR_BITS-1:0] RST_IDLE_TIME       = 24'd2000;
  localparam logic [DUR_BITS-1:0] RST_MANUAL_TIME     = 24'd5000;
  localparam logic [CNT_BITS-1:0] RST_CYCLE_TOTAL     = 8'd10;
  localparam logic [DUR_BITS-1:0] RST_FINAL_VENT_TIME = 24'd5000;
  localparam logic [CNT_BITS-1:0] RST_DEBOUNCE_TIME   = 8'd5;

  localparam logic TARGET_PUMP = 1'b0;
  localparam logic TARGET_VENT = 1'b1;

  typedef struct packed {
    logic [DUR_BITS-1:0] pump_ticks;
    logic [DUR_BITS-1:0] vent_ticks;
    logic [DUR_BITS-1:0] pause_ticks;
    logic [DUR_BITS-1:0] manual_time;
    logic [CNT_BITS-1:0] cycle_total;
    logic [DUR_BITS-1:0] final_vent_time;
  } seq_cfg_t;

  typedef struct packed {
    logic start;
    logic pump;
    logic vent;
  } press_t;

  typedef struct packed {
    logic                  pump_drive;
    logic                  vent_drive;
    logic                  status_lamp;
    logic                  busy_res;
    logic [PHASE_BITS-1:0] phase;
    logic [CNT_BITS-1:0]   cycle_number;
  } result_t;

endpackage

// ----- design/timed_pump_vent_purge_sequencer.sv -----
// Top level of the timed pump, vent and purge sequencer.
//
// Each input item is one millisecond tick carrying the raw, active-low levels
// of the start, manual-pump and manual-vent buttons. Every item gives exactly
// one result item: the pump and vent drives, the status lamp, the busy flag,
// the phase code and the running purge cycle index.
//
// An accepted item is held in an input register; as soon as the result queue has
// room, the three debouncers and the phase sequencer step once and the result is
// written into a two-entry result queue, from which it is offered to the receiver.
// One item is accepted in every cycle for as long as the receiver takes results.
//
// When the receiver stalls, the queue absorbs results until both entries are
// full; after that the input register holds its item and in_stall is raised.
// The user must write the configuration registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// An index beyond the register list is ignored. Synchronous reset clears the
// queue, returns the sequencer to idle, marks all buttons released and restores
// the default timings.
module timed_pump_vent_purge_sequencer #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_level,
  input  logic                              pump_level,
  input  logic                              vent_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pump_drive,
  output logic                              vent_drive,
  output logic                              status_lamp,
  output logic                              busy_res,
  output logic [tpvp_pkg::PHASE_BITS-1:0]   phase,
  output logic [tpvp_pkg::CNT_BITS-1:0]     cycle_number,
  input  logic                              cfg_we,
  input  logic [tpvp_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [tpvp_pkg::DUR_BITS-1:0]     cfg_data
);
  import tpvp_pkg::*;

  // Configuration registers.
  seq_cfg_t            cfg;
  logic [CNT_BITS-1:0] settle_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pump_ticks      <= RST_PUMP_TIME;
      cfg.vent_ticks      <= RST_VENT_TIME;
      cfg.pause_ticks     <= RST_IDLE_TIME;
      cfg.manual_time     <= RST_MANUAL_TIME;
      cfg.cycle_total     <= RST_CYCLE_TOTAL;
      cfg.final_vent_time <= RST_FINAL_VENT_TIME;
      settle_limit        <= RST_DEBOUNCE_TIME;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PUMP_TIME:       cfg.pump_ticks      <= cfg_data;
        REG_VENT_TIME:       cfg.vent_ticks      <= cfg_data;
        REG_IDLE_TIME:       cfg.pause_ticks     <= cfg_data;
        REG_MANUAL_TIME:     cfg.manual_time     <= cfg_data;
        REG_CYCLE_TOTAL:     cfg.cycle_total     <= cfg_data[CNT_BITS-1:0];
        REG_FINAL_VENT_TIME: cfg.final_vent_time <= cfg_data;
        REG_DEBOUNCE_TIME:   settle_limit        <= cfg_data[CNT_BITS-1:0];
        default: begin
          settle_limit <= settle_limit;
        end
      endcase
    end
  end

  // Input register: one tick item waiting to be processed.
  logic    in_held;
  logic    in_held_next;
  logic    start_q;
  logic    pump_q;
  logic    vent_q;
  logic    room;
  logic    step;
  logic    accept;
  press_t  press;
  result_t res;
  result_t head;

  // The held item is processed as soon as the result queue can take its result.
  assign step     = in_held && room;
  assign in_stall = in_held && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      in_held_next = 1'b1;
    end else if (step) begin
      in_held_next = 1'b0;
    end else begin
      in_held_next = in_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else begin
      in_held <= in_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= start_level;
      pump_q  <= pump_level;
      vent_q  <= vent_level;
    end
  end

  // The buttons are debounced on every tick, busy or not.
  tpvp_debounce u_db_start (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .raw          (start_q),
    .settle_limit (settle_limit),
    .press        (press.start)
  );

  tpvp_debounce u_db_pump (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .raw          (pump_q),
    .settle_limit (settle_limit),
    .press        (press.pump)
  );

  tpvp_debounce u_db_vent (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .raw          (vent_q),
    .settle_limit (settle_limit),
    .press        (press.vent)
  );

  tpvp_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .press (press),
    .cfg   (cfg),
    .res   (res)
  );

  tpvp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .din       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (head)
  );

  assign pump_drive   = head.pump_drive;
  assign vent_drive   = head.vent_drive;
  assign status_lamp  = head.status_lamp;
  assign busy_res     = head.busy_res;
  assign phase        = head.phase;
  assign cycle_number = head.cycle_number;

endmodule

// ----- design/tpvp_debounce.sv -----
// Debouncer for one active-low button, stepped once per tick item.
module tpvp_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          raw,
  input  logic [tpvp_pkg::CNT_BITS-1:0] settle_limit,
  output logic                          press
);
  import tpvp_pkg::*;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  logic                stable;
  logic                stable_next;
  logic                last_raw;
  logic [CNT_BITS-1:0] bounce;
  logic [CNT_BITS-1:0] bounce_next;
  logic                take;

  always_comb begin
    if (raw != last_raw) begin
      bounce_next = '0;
    end else if (bounce != CNT_MAX) begin
      bounce_next = bounce + 1'b1;
    end else begin
      bounce_next = bounce;
    end
    take        = (bounce_next >= settle_limit) && (raw != stable);
    stable_next = take ? raw : stable;
    press       = take && !raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable   <= 1'b1;
      last_raw <= 1'b1;
      bounce   <= '0;
    end else if (step) begin
      stable   <= stable_next;
      last_raw <= raw;
      bounce   <= bounce_next;
    end
  end

endmodule

// ----- design/tpvp_seq.sv -----
// Phase sequencer: phase, phase timer, cycle counter and the result of each tick.
module tpvp_seq #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  tpvp_pkg::press_t   press,
  input  tpvp_pkg::seq_cfg_t cfg,
  output tpvp_pkg::result_t  res
);
  import tpvp_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic [CNT_BITS-1:0]   cycle;
  logic [CNT_BITS-1:0]   cycle_next;
  logic                  target;
  logic                  target_next;
  logic                  load;
  logic [DUR_BITS-1:0]   dur;
  logic [TIMER_BITS-1:0] dur_cut;
  logic                  more_cycles;

  assign more_cycles = ({1'b0, cycle} + 9'd1) < {1'b0, cfg.cycle_total};

  always_comb begin
    phase_next  = phase;
    timer_next  = timer;
    cycle_next  = cycle;
    target_next = target;
    load        = 1'b0;
    dur         = cfg.pause_ticks;

    if (phase == PH_IDLE) begin
      cycle_next = '0;
      if (press.start) begin
        load = 1'b1;
        if (cfg.cycle_total == '0) begin
          phase_next = PH_FINAL_VENT;
          dur        = cfg.final_vent_time;
        end else begin
          phase_next = PH_PUMP;
          dur        = cfg.pump_ticks;
        end
      end else if (press.pump || press.vent) begin
        // Pump wins when both manual buttons are pressed on the same tick.
        load        = 1'b1;
        target_next = press.pump ? TARGET_PUMP : TARGET_VENT;
        phase_next  = PH_MAN_ON;
        dur         = cfg.manual_time;
      end
    end else if (phase > PH_MAN_IDLE) begin
      phase_next = PH_IDLE;
      timer_next = '0;
      cycle_next = '0;
    end else if (timer != '0) begin
      timer_next = timer - 1'b1;
    end else begin
      case (phase)
        PH_PUMP: begin
          load       = 1'b1;
          phase_next = PH_PUMP_IDLE;
        end
        PH_PUMP_IDLE: begin
          load       = 1'b1;
          phase_next = PH_VENT;
          dur        = cfg.vent_ticks;
        end
        PH_VENT: begin
          load       = 1'b1;
          phase_next = PH_VENT_IDLE;
        end
        PH_VENT_IDLE: begin
          load = 1'b1;
          if (more_cycles) begin
            cycle_next = cycle + 1'b1;
            phase_next = PH_PUMP;
            dur        = cfg.pump_ticks;
          end else begin
            phase_next = PH_FINAL_VENT;
            dur        = cfg.final_vent_time;
          end
        end
        PH_FINAL_VENT: begin
          load       = 1'b1;
          phase_next = PH_FINAL_IDLE;
        end
        PH_MAN_ON: begin
          load       = 1'b1;
          phase_next = PH_MAN_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
          timer_next = '0;
          cycle_next = '0;
        end
      endcase
    end

    // A phase lasts max(duration, 1) ticks; the timer holds the ticks left after this one.
    dur_cut = TIMER_BITS'(dur);
    if (load) begin
      timer_next = (dur_cut == '0) ? '0 : dur_cut - 1'b1;
    end
  end

  always_comb begin
    res.pump_drive   = (phase_next == PH_PUMP) ||
                       ((phase_next == PH_MAN_ON) && (target_next == TARGET_PUMP));
    res.vent_drive   = (phase_next == PH_VENT) || (phase_next == PH_FINAL_VENT) ||
                       ((phase_next == PH_MAN_ON) && (target_next == TARGET_VENT));
    res.status_lamp  = phase_next inside {[PH_PUMP:PH_FINAL_IDLE]};
    res.busy_res     = phase_next != PH_IDLE;
    res.phase        = phase_next;
    res.cycle_number = res.status_lamp ? cycle_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      timer  <= '0;
      cycle  <= '0;
      target <= TARGET_PUMP;
    end else if (step) begin
      phase  <= phase_next;
      timer  <= timer_next;
      cycle  <= cycle_next;
      target <= target_next;
    end
  end

endmodule

// ----- design/tpvp_outq.sv -----
// Two-entry result queue that decouples the sequencer from the output stall.
module tpvp_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tpvp_pkg::result_t din,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output tpvp_pkg::result_t dout
);
  import tpvp_pkg::*;

  result_t    entry0;
  result_t    entry1;
  logic [1:0] count;
  logic       pop;

  assign out_valid = count != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign room      = (count != 2'd2) || pop;
  assign dout      = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          entry0 <= din;
        end else begin
          entry1 <= din;
        end
      end
      2'b01: begin
        entry0 <= entry1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          entry0 <= din;
        end else begin
          entry0 <= entry1;
          entry1 <= din;
        end
      end
      default: begin
        entry0 <= entry0;
      end
    endcase
  end

endmodule

// ----- design/tpvp_checker.sv -----
// Port-level checks of the sequencer and the bind that attaches them.
module tpvp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            pump_drive,
  input logic                            vent_drive,
  input logic                            status_lamp,
  input logic                            busy_res,
  input logic [tpvp_pkg::PHASE_BITS-1:0] phase,
  input logic [tpvp_pkg::CNT_BITS-1:0]   cycle_number
);
  import tpvp_pkg::*;

  // A result that is not busy shows the idle phase with every output off.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |->
      (phase == PH_IDLE) && !pump_drive && !vent_drive && !status_lamp)
    else $error("idle result drives an output");

  // The pump and the vent are never driven together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pump_drive && vent_drive))
    else $error("pump and vent driven together");

  // The lamp is lit exactly in the automatic phases.
  a_lamp_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_lamp == ((phase >= PH_PUMP) && (phase <= PH_FINAL_IDLE))))
    else $error("status lamp does not match phase");

  // Outside an automatic sequence the cycle index reads zero.
  a_cycle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status_lamp) |-> (cycle_number == '0))
    else $error("cycle index set outside a sequence");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

endmodule

bind timed_pump_vent_purge_sequencer tpvp_checker u_tpvp_checker (.*);
